/* rtl/core/dctq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctq_pkg: shared types and constants for the delta clock timer queue
// Item layouts for the command and result channels, result and kind codes,
// and the layout of one stored timer entry.
// ----------------------------------------------------------------------------
package dctq_pkg;

  localparam int DELAY_BITS  = 16;
  localparam int HANDLE_BITS = 8;
  localparam int PEND_BITS   = 7;
  localparam int CODE_BITS   = 2;
  // one extra bit so a decremented top delta can go below zero
  localparam int DELTA_W     = DELAY_BITS + 1;

  // command kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // result codes
  localparam logic [CODE_BITS-1:0] RES_ACCEPT  = 2'd0;
  localparam logic [CODE_BITS-1:0] RES_FULL    = 2'd1;
  localparam logic [CODE_BITS-1:0] RES_EXPIRED = 2'd2;

  typedef struct packed {
    logic                   kind;
    logic [DELAY_BITS-1:0]  delay;
    logic [HANDLE_BITS-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]   result_code;
    logic [HANDLE_BITS-1:0] expired_handle;
    logic [PEND_BITS-1:0]   pending;
    logic                   last;
  } out_item_t;

  // one timer list entry as held in the entry memory
  typedef struct packed {
    logic [DELTA_W-1:0]     delta;
    logic [HANDLE_BITS-1:0] handle;
  } ent_t;

endpackage

/* rtl/core/delta_clock_timer_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_clock_timer_queue_top: sorted delta-time timer list
// Entries hold the ticks after the entry just ahead of them; the soonest
// entry sits in slot count-1. One sequencer walks the list entry by entry.
//
//   channel  | signals               | direction | handshake
//   ---------+-----------------------+-----------+---------------------------
//   command  | start, busy, cmd      | in        | taken when start & !busy
//   result   | rsp_valid, rsp        | out       | one-cycle strobe, no stall
//
// Insert: one memory read-compare step per entry passed or stopped at, then
// the final write; a full list is answered from idle without a walk. Tick:
// one step per expired entry. The walk is paced by the single-port read of
// the entry memory. Reset clears the state, count and flags; the memory
// needs no clearing. Results come out as strobes the receiver must take.
// ----------------------------------------------------------------------------
module delta_clock_timer_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dctq_pkg::in_item_t  cmd,
  output logic                rsp_valid,
  output dctq_pkg::out_item_t rsp
);
  import dctq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_TK_CHK,
    ST_TK_LAST
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic [DELTA_W-1:0]     cur_d;
  logic [HANDLE_BITS-1:0] cur_h;
  logic [HANDLE_BITS-1:0] pend_h;
  logic                   have_pend;
  logic                   first;

  // entry memory, one write and one registered read per cycle
  ent_t                   mem [DEPTH];
  ent_t                   rd_ent;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [AW-1:0]          wr_addr;
  ent_t                   wr_ent;

  // compare/subtract signals for the insert and tick walks
  logic [DELTA_W-1:0]     dval;
  logic                   pops;
  logic                   ins_gt;

  assign busy = (state != ST_IDLE);

  assign dval   = rd_ent.delta - DELTA_W'(first);
  assign pops   = dval[DELTA_W-1] | (dval == '0);
  assign ins_gt = cur_d > rd_ent.delta;

  // memory address and write control
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = '0;
    wr_ent  = '0;
    unique case (state)
      ST_IDLE: begin
        // both commands start by reading the top entry
        rd_addr = AW'(count - CW'(1));
      end
      ST_INS_CMP: begin
        if (ins_gt) begin
          // passed entry moves one slot up
          we      = 1'b1;
          wr_addr = AW'(idx);
          wr_ent  = rd_ent;
          rd_addr = AW'(idx - CW'(2));
        end else begin
          // entry just behind the new one has its delta reduced by the new delta
          we            = 1'b1;
          wr_addr       = AW'(idx - CW'(1));
          wr_ent.delta  = rd_ent.delta - cur_d;
          wr_ent.handle = rd_ent.handle;
        end
      end
      ST_INS_PUT: begin
        we            = 1'b1;
        wr_addr       = AW'(idx);
        wr_ent.delta  = cur_d;
        wr_ent.handle = cur_h;
      end
      ST_TK_CHK: begin
        if (pops) begin
          rd_addr = AW'(count - CW'(2));
        end else if (first) begin
          // top not due: store decremented delta
          we            = 1'b1;
          wr_addr       = AW'(count - CW'(1));
          wr_ent.delta  = dval;
          wr_ent.handle = rd_ent.handle;
        end
      end
      ST_TK_LAST: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_ent <= mem[rd_addr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      have_pend <= 1'b0;
      first     <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (cmd.kind == KIND_INSERT) begin
              if (count == CW'(DEPTH)) begin
                rsp.result_code    <= RES_FULL;
                rsp.expired_handle <= '0;
                rsp.pending        <= PEND_BITS'(count);
                rsp.last           <= 1'b1;
                rsp_valid          <= 1'b1;
              end else begin
                cur_d <= {1'b0, cmd.delay};
                cur_h <= cmd.handle;
                idx   <= count;
                state <= (count == '0) ? ST_INS_PUT : ST_INS_CMP;
              end
            end else if (count != '0) begin
              first     <= 1'b1;
              have_pend <= 1'b0;
              state     <= ST_TK_CHK;
            end
          end
        end
        ST_INS_CMP: begin
          if (ins_gt) begin
            cur_d <= cur_d - rd_ent.delta;
            idx   <= idx - CW'(1);
            if (idx == CW'(1)) begin
              state <= ST_INS_PUT;
            end
          end else begin
            state <= ST_INS_PUT;
          end
        end
        ST_INS_PUT: begin
          count              <= count + CW'(1);
          rsp.result_code    <= RES_ACCEPT;
          rsp.expired_handle <= '0;
          rsp.pending        <= PEND_BITS'(count + CW'(1));
          rsp.last           <= 1'b1;
          rsp_valid          <= 1'b1;
          state              <= ST_IDLE;
        end
        ST_TK_CHK: begin
          first <= 1'b0;
          // previous pop goes out once we know whether another follows
          if (have_pend) begin
            rsp.result_code    <= RES_EXPIRED;
            rsp.expired_handle <= pend_h;
            rsp.pending        <= PEND_BITS'(count);
            rsp.last           <= ~pops;
            rsp_valid          <= 1'b1;
          end
          if (pops) begin
            pend_h    <= rd_ent.handle;
            have_pend <= 1'b1;
            count     <= count - CW'(1);
            state     <= (count == CW'(1)) ? ST_TK_LAST : ST_TK_CHK;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_TK_LAST: begin
          rsp.result_code    <= RES_EXPIRED;
          rsp.expired_handle <= pend_h;
          rsp.pending        <= PEND_BITS'(count);
          rsp.last           <= 1'b1;
          rsp_valid          <= 1'b1;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
